/* rtl/cct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, sizes and the fixed channel table of the cosmic counter
// trigger.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int NUM_CHANNELS = 20;
  localparam int NUM_PAIRS    = 5;
  localparam int CH_W         = 5;
  localparam int SIG_W        = 24;
  localparam int TIME_W       = 16;
  localparam int ENTRY_W      = SIG_W + TIME_W;
  localparam int MASK_W       = NUM_PAIRS;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  // Register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CUT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COINC_THRESHOLD = 2'd2;

  // Reset values, u.4 fixed point
  localparam logic [SIG_W-1:0]  HIT_THRESHOLD_RST   = 24'd16000;
  localparam logic [TIME_W-1:0] TIME_CUT_RST        = 16'd800;
  localparam logic [SIG_W-1:0]  COINC_THRESHOLD_RST = 24'd16000;

  // Input command codes
  localparam logic CMD_HIT = 1'b0;
  localparam logic CMD_EOE = 1'b1;

  // Result kind codes
  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM
  } state_t;

  // Raw counter channel to mapped channel
  function automatic logic [CH_W-1:0] chan_map(input logic [CH_W-1:0] raw);
    logic [CH_W-1:0] m;
    case (raw)
      5'd0:    m = 5'd4;
      5'd1:    m = 5'd5;
      5'd2:    m = 5'd2;
      5'd3:    m = 5'd3;
      5'd4:    m = 5'd6;
      5'd5:    m = 5'd7;
      5'd6:    m = 5'd0;
      5'd7:    m = 5'd1;
      5'd8:    m = 5'd12;
      5'd9:    m = 5'd13;
      5'd10:   m = 5'd10;
      5'd11:   m = 5'd11;
      5'd12:   m = 5'd14;
      5'd13:   m = 5'd15;
      5'd14:   m = 5'd8;
      5'd15:   m = 5'd9;
      5'd16:   m = 5'd16;
      5'd17:   m = 5'd17;
      5'd18:   m = 5'd18;
      5'd19:   m = 5'd19;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/cct_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cosmic_counter_trigger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosmic_counter_trigger
// Collects one event's counter hits in a channel store and, at end of event,
// reports the hits that pass the cuts followed by a trigger summary word.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken when start is high and busy is low. cmd = hit stores the
//   hit (if its channel is known and its signal is over hit_threshold) in
//   the same cycle; hits can follow back to back and give no result.
//   cmd = end of event raises busy and walks the 20-entry store, one read of
//   the store RAM per cycle. Each stored hit that passes the signal and time
//   cuts appears for one cycle with strobe high and kind = hit, in rising
//   channel order, followed by the summary word (kind = summary, last = 1).
//   Busy falls once all 20 entries have been read and the summary word has
//   been given. The store's valid bits are cleared with the summary.
//   Results cannot be held off by the receiver; strobe marks each one.
//   Register writes (wr_en, wr_index, wr_data) take effect at once; indexes
//   beyond the register list are ignored. Reset restores the register
//   defaults and empties the store; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cosmic_counter_trigger (
  input  logic                           clk,
  input  logic                           rst,
  // register write port
  input  logic                           wr_en,
  input  logic [cct_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [cct_pkg::CFG_DATA_W-1:0] wr_data,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [cct_pkg::CH_W-1:0]       raw_channel,
  input  logic [cct_pkg::SIG_W-1:0]      signal,
  input  logic [cct_pkg::TIME_W-1:0]     hit_time,
  // result side
  output logic                           strobe,
  output logic                           kind,
  output logic [cct_pkg::CH_W-1:0]       channel,
  output logic [cct_pkg::SIG_W-1:0]      out_signal,
  output logic [cct_pkg::TIME_W-1:0]     out_time,
  output logic [cct_pkg::MASK_W-1:0]     up_any,
  output logic [cct_pkg::MASK_W-1:0]     down_any,
  output logic [cct_pkg::MASK_W-1:0]     up_coincidence,
  output logic [cct_pkg::MASK_W-1:0]     down_coincidence,
  output logic                           trigger,
  output logic                           last
);

  import cct_pkg::*;

  localparam int ADDR_W = $clog2(NUM_CHANNELS);

  // Configuration registers
  logic [SIG_W-1:0]  hit_threshold;
  logic [TIME_W-1:0] time_cut;
  logic [SIG_W-1:0]  coincidence_threshold;

  // Control state
  state_t                  state, state_next;
  logic [ADDR_W-1:0]       cnt;
  logic [NUM_CHANNELS-1:0] valid;
  logic [NUM_CHANNELS-1:0] over, over_next;

  // Store RAM ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Decode of the accepted word
  logic              accept;
  logic              hit_store;
  logic              eoe_go;
  logic [CH_W-1:0]   mapped;

  // Scan datapath
  logic              scan_data;
  logic              scan_last;
  logic [ADDR_W-1:0] idx;
  logic [SIG_W-1:0]  rd_sig;
  logic [TIME_W-1:0] rd_time;
  logic              rd_valid;
  logic              report;

  // Summary masks
  logic [MASK_W-1:0] up_m, dn_m, upc_m, dnc_m;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign mapped = chan_map(raw_channel);

  assign hit_store = accept && (cmd == CMD_HIT) &&
                     (raw_channel < CH_W'(NUM_CHANNELS)) && (signal > hit_threshold);
  assign eoe_go    = accept && (cmd == CMD_EOE);

  // Channel store: signal in the upper bits, time in the lower
  cct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_threshold         <= HIT_THRESHOLD_RST;
      time_cut              <= TIME_CUT_RST;
      coincidence_threshold <= COINC_THRESHOLD_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_HIT_THRESHOLD:   hit_threshold         <= wr_data[SIG_W-1:0];
        REG_TIME_CUT:        time_cut              <= wr_data[TIME_W-1:0];
        REG_COINC_THRESHOLD: coincidence_threshold <= wr_data[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (eoe_go) state_next = ST_SCAN;
      ST_SCAN: if (scan_last) state_next = ST_SUM;
      ST_SUM:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs: store access and scan strobes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mapped[ADDR_W-1:0];
    ram_wdata = {signal, hit_time};
    ram_raddr = cnt;
    scan_data = 1'b0;
    scan_last = 1'b0;
    case (state)
      ST_IDLE: ram_we = hit_store;
      ST_SCAN: begin
        // data for entry cnt-1 is on the read port once cnt is past zero
        scan_data = (cnt != '0);
        scan_last = (cnt == ADDR_W'(NUM_CHANNELS));
      end
      default: ;
    endcase
  end

  // Evaluate the entry coming out of the store
  assign idx      = cnt - ADDR_W'(1);
  assign rd_sig   = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_time  = ram_rdata[TIME_W-1:0];
  assign rd_valid = valid[idx];
  assign report   = scan_data && rd_valid && (rd_sig > hit_threshold) &&
                    (rd_time > time_cut);

  always_comb begin
    over_next = over;
    if (scan_data) begin
      over_next[idx] = rd_valid && (rd_sig > coincidence_threshold);
    end
  end

  // Pair masks over the finished over-threshold vector
  always_comb begin
    for (int i = 0; i < NUM_PAIRS; i++) begin
      up_m[i]  = over[i] | over[i+10];
      upc_m[i] = over[i] & over[i+10];
      dn_m[i]  = over[i+5] | over[i+15];
      dnc_m[i] = over[i+5] & over[i+15];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        cnt <= cnt + ADDR_W'(1);
      end else begin
        cnt <= '0;
      end
      if (state == ST_SUM) begin
        valid <= '0;
      end else if (hit_store) begin
        valid[mapped[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Over-threshold vector, rebuilt during each scan
  always_ff @(posedge clk) begin
    if (eoe_go) begin
      over <= '0;
    end else begin
      over <= over_next;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= report || (state == ST_SUM);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (report) begin
      kind             <= KIND_HIT;
      channel          <= idx;
      out_signal       <= rd_sig;
      out_time         <= rd_time;
      up_any           <= '0;
      down_any         <= '0;
      up_coincidence   <= '0;
      down_coincidence <= '0;
      trigger          <= 1'b0;
      last             <= 1'b0;
    end else if (state == ST_SUM) begin
      kind             <= KIND_SUMMARY;
      channel          <= '0;
      out_signal       <= '0;
      out_time         <= '0;
      up_any           <= up_m;
      down_any         <= dn_m;
      up_coincidence   <= upc_m;
      down_coincidence <= dnc_m;
      trigger          <= (up_m != '0) && (dn_m != '0);
      last             <= 1'b1;
    end
  end

endmodule

/* tb/cct_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_checker
// Watches the command, register-write and result ports of the cosmic counter
// trigger. It keeps its own channel store and cuts, works out the words each
// end of event must give, and compares every strobed word field by field
// with the oldest one still expected. Mismatches are counted for the test top.
// ----------------------------------------------------------------------------
module cct_checker
  import cct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  cmd,
  input  logic [CH_W-1:0]       raw_channel,
  input  logic [SIG_W-1:0]      signal,
  input  logic [TIME_W-1:0]     hit_time,
  input  logic                  strobe,
  input  logic                  kind,
  input  logic [CH_W-1:0]       channel,
  input  logic [SIG_W-1:0]      out_signal,
  input  logic [TIME_W-1:0]     out_time,
  input  logic [MASK_W-1:0]     up_any,
  input  logic [MASK_W-1:0]     down_any,
  input  logic [MASK_W-1:0]     up_coincidence,
  input  logic [MASK_W-1:0]     down_coincidence,
  input  logic                  trigger,
  input  logic                  last,
  input  logic                  end_of_run,
  output int                    errors,
  output int                    outstanding
);

  // Raw counter channel to mapped channel, entry 0 in the low bits
  localparam logic [NUM_CHANNELS*CH_W-1:0] REMAP = {
    5'd19, 5'd18, 5'd17, 5'd16, 5'd9,  5'd8,  5'd15, 5'd14, 5'd11, 5'd10,
    5'd13, 5'd12, 5'd1,  5'd0,  5'd7,  5'd6,  5'd3,  5'd2,  5'd5,  5'd4
  };

  typedef struct packed {
    logic              kind;
    logic [CH_W-1:0]   channel;
    logic [SIG_W-1:0]  sig;
    logic [TIME_W-1:0] tim;
    logic [MASK_W-1:0] up;
    logic [MASK_W-1:0] dn;
    logic [MASK_W-1:0] upc;
    logic [MASK_W-1:0] dnc;
    logic              trig;
    logic              fin;
  } trig_word_t;

  // Cuts as last written
  logic [SIG_W-1:0]        cut_hit;
  logic [TIME_W-1:0]       cut_time;
  logic [SIG_W-1:0]        cut_coinc;

  // Channel store of the event being collected
  logic [SIG_W-1:0]        held_signal [NUM_CHANNELS];
  logic [TIME_W-1:0]       held_time   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] held_mask;

  trig_word_t              event_words [$];
  bit                      leftovers_checked;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report(input string what);
    $display("ERROR [%0t] %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  function automatic bit over_coinc(input int ch);
    return held_mask[ch] && (held_signal[ch] > cut_coinc);
  endfunction

  // Hit word: kept only if its channel is known and its signal above the cut
  task automatic store_hit(input logic [CH_W-1:0] raw, input logic [SIG_W-1:0] sig,
                           input logic [TIME_W-1:0] tim);
    logic [CH_W-1:0] ch;
    if (raw < NUM_CHANNELS && sig > cut_hit) begin
      ch               = REMAP[raw*CH_W +: CH_W];
      held_signal[ch]  = sig;
      held_time[ch]    = tim;
      held_mask[ch]    = 1'b1;
    end
  endtask

  // End of event: reported hits in channel order, then the summary word
  task automatic close_event();
    trig_word_t        w;
    logic [MASK_W-1:0] up, dn, upc, dnc;
    bit                a, b, c, d;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (held_mask[i] && held_signal[i] > cut_hit && held_time[i] > cut_time) begin
        w         = '0;
        w.kind    = KIND_HIT;
        w.channel = CH_W'(i);
        w.sig     = held_signal[i];
        w.tim     = held_time[i];
        event_words.push_back(w);
      end
    end
    up = '0; dn = '0; upc = '0; dnc = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      a = over_coinc(p);
      b = over_coinc(p + 10);
      c = over_coinc(p + 5);
      d = over_coinc(p + 15);
      up[p]  = a | b;
      upc[p] = a & b;
      dn[p]  = c | d;
      dnc[p] = c & d;
    end
    w      = '0;
    w.kind = KIND_SUMMARY;
    w.up   = up;
    w.dn   = dn;
    w.upc  = upc;
    w.dnc  = dnc;
    w.trig = (up != '0) && (dn != '0);
    w.fin  = 1'b1;
    event_words.push_back(w);
    held_mask = '0;
  endtask

  task automatic check_word();
    trig_word_t want;
    if (event_words.size() == 0) begin
      report($sformatf("word with nothing expected: kind %0d channel %0d", kind, channel));
      return;
    end
    want = event_words.pop_front();
    check_field("kind", 32'(kind), 32'(want.kind));
    check_field("channel", 32'(channel), 32'(want.channel));
    check_field("out_signal", 32'(out_signal), 32'(want.sig));
    check_field("out_time", 32'(out_time), 32'(want.tim));
    check_field("up_any", 32'(up_any), 32'(want.up));
    check_field("down_any", 32'(down_any), 32'(want.dn));
    check_field("up_coincidence", 32'(up_coincidence), 32'(want.upc));
    check_field("down_coincidence", 32'(down_coincidence), 32'(want.dnc));
    check_field("trigger", 32'(trigger), 32'(want.trig));
    check_field("last", 32'(last), 32'(want.fin));
  endtask

  // Everything is judged on values held just before the rising edge
  always @(posedge clk) begin
    if (rst) begin
      cut_hit   = HIT_THRESHOLD_RST;
      cut_time  = TIME_CUT_RST;
      cut_coinc = COINC_THRESHOLD_RST;
      held_mask = '0;
      event_words.delete();
    end else begin
      if ($isunknown(strobe))
        report("strobe unknown");
      else if (strobe)
        check_word();
      if (wr_en) begin
        case (wr_index)
          REG_HIT_THRESHOLD:   cut_hit   = wr_data;
          REG_TIME_CUT:        cut_time  = wr_data[TIME_W-1:0];
          REG_COINC_THRESHOLD: cut_coinc = wr_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (cmd == CMD_HIT)
          store_hit(raw_channel, signal, hit_time);
        else
          close_event();
      end
      if (end_of_run && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (event_words.size() != 0)
          report($sformatf("%0d words still expected at end", event_words.size()));
      end
    end
    outstanding = event_words.size();
  end

endmodule

/* tb/cosmic_counter_trigger_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosmic_counter_trigger_test
// Drives events of counter hits into the cosmic counter trigger in random
// bursts, under several settings of the cuts, and leaves all checking of the
// result words to cct_checker. Gives the verdict once every word is in.
// ----------------------------------------------------------------------------
module cosmic_counter_trigger_test;
  import cct_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not a register
  localparam int EOE_CYCLES  = 22;
  localparam int PHASE_WORDS = 16;
  localparam int NUM_PHASES  = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [SIG_W-1:0]  SIG_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index    = '0;
  logic [CFG_DATA_W-1:0] wr_data     = '0;
  logic                  start       = 1'b0;
  logic                  cmd         = CMD_HIT;
  logic [CH_W-1:0]       raw_channel = '0;
  logic [SIG_W-1:0]      signal      = '0;
  logic [TIME_W-1:0]     hit_time    = '0;
  logic                  busy;
  logic                  strobe;
  logic                  kind;
  logic [CH_W-1:0]       channel;
  logic [SIG_W-1:0]      out_signal;
  logic [TIME_W-1:0]     out_time;
  logic [MASK_W-1:0]     up_any;
  logic [MASK_W-1:0]     down_any;
  logic [MASK_W-1:0]     up_coincidence;
  logic [MASK_W-1:0]     down_coincidence;
  logic                  trigger;
  logic                  last;

  logic                  end_of_run  = 1'b0;
  int                    errors;
  int                    outstanding;
  int                    cycles      = 0;
  int                    burst_left  = 4;
  int                    words_sent  = 0;

  // Current cuts, only used to aim random values at the edges
  logic [SIG_W-1:0]      aim_hit     = HIT_THRESHOLD_RST;
  logic [TIME_W-1:0]     aim_time    = TIME_CUT_RST;
  logic [SIG_W-1:0]      aim_coinc   = COINC_THRESHOLD_RST;

  cosmic_counter_trigger DUT (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .raw_channel      (raw_channel),
    .signal           (signal),
    .hit_time         (hit_time),
    .strobe           (strobe),
    .kind             (kind),
    .channel          (channel),
    .out_signal       (out_signal),
    .out_time         (out_time),
    .up_any           (up_any),
    .down_any         (down_any),
    .up_coincidence   (up_coincidence),
    .down_coincidence (down_coincidence),
    .trigger          (trigger),
    .last             (last)
  );

  cct_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .start            (start),
    .busy             (busy),
    .cmd              (cmd),
    .raw_channel      (raw_channel),
    .signal           (signal),
    .hit_time         (hit_time),
    .strobe           (strobe),
    .kind             (kind),
    .channel          (channel),
    .out_signal       (out_signal),
    .out_time         (out_time),
    .up_any           (up_any),
    .down_any         (down_any),
    .up_coincidence   (up_coincidence),
    .down_coincidence (down_coincidence),
    .trigger          (trigger),
    .last             (last),
    .end_of_run       (end_of_run),
    .errors           (errors),
    .outstanding      (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present a word and hold it until taken; busy is judged at the falling edge
  task automatic send_word(input logic c, input logic [CH_W-1:0] raw,
                           input logic [SIG_W-1:0] sig, input logic [TIME_W-1:0] tim);
    bit taken;
    start       <= 1'b1;
    cmd         <= c;
    raw_channel <= raw;
    signal      <= sig;
    hit_time    <= tim;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (c == CMD_EOE || raw < NUM_CHANNELS)
      words_sent++;
  endtask

  // Sender gap: start low, junk on the fields
  task automatic pause_sender(input int n);
    start       <= 1'b0;
    cmd         <= 1'($urandom);
    raw_channel <= CH_W'($urandom);
    signal      <= SIG_W'($urandom);
    hit_time    <= TIME_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length, now and then a long one with no gaps
  task automatic next_slot();
    burst_left--;
    if (burst_left <= 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                               : $urandom_range(1, 6);
    end
  endtask

  // Wait until every expected word is in and the block has settled
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (outstanding != 0);
    repeat (EOE_CYCLES + 3) @(posedge clk);
  endtask

  // Write all three cuts, preceded by a write to the unused index
  task automatic set_config(input logic [SIG_W-1:0] thr, input logic [TIME_W-1:0] tcut,
                            input logic [SIG_W-1:0] coinc);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    wait_drained();
    idx[0] = REG_SPARE;           val[0] = CFG_DATA_W'($urandom);
    idx[1] = REG_HIT_THRESHOLD;   val[1] = thr;
    idx[2] = REG_TIME_CUT;        val[2] = {8'($urandom), tcut};
    idx[3] = REG_COINC_THRESHOLD; val[3] = coinc;
    for (int k = 0; k < 4; k++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[k];
      wr_data  <= val[k];
      @(posedge clk);
    end
    wr_en     <= 1'b0;
    aim_hit   = thr;
    aim_time  = tcut;
    aim_coinc = coinc;
  endtask

  function automatic logic [SIG_W-1:0] pick_signal();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SIG_MAX;
      2:       return aim_hit;
      3:       return aim_hit + 1'b1;
      4:       return aim_coinc;
      5:       return aim_coinc + 1'b1;
      default: return SIG_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TIME_MAX;
      2:       return aim_time;
      3:       return aim_time + 1'b1;
      default: return TIME_W'($urandom);
    endcase
  endfunction

  // One event: a few hits, some on unknown channels, then end of event
  task automatic send_event(input int n_hits);
    logic [CH_W-1:0] raw;
    for (int k = 0; k < n_hits; k++) begin
      if ($urandom_range(0, 9) == 0)
        raw = CH_W'($urandom_range(NUM_CHANNELS, 31));
      else if ($urandom_range(0, 3) == 0)
        raw = CH_W'($urandom_range(0, 3));   // crowd a few channels to overwrite
      else
        raw = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      send_word(CMD_HIT, raw, pick_signal(), pick_time());
      next_slot();
    end
    send_word(CMD_EOE, CH_W'($urandom), SIG_W'($urandom), TIME_W'($urandom));
    next_slot();
  endtask

  initial begin
    logic [SIG_W-1:0]  thr, coinc;
    logic [TIME_W-1:0] tcut;
    int                phase_start;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every raw channel under the reset cuts: fills the whole store, longest
    // output; one hit sits exactly on the time cut
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      send_word(CMD_HIT, CH_W'(i),
                (i % 2 == 0) ? SIG_MAX - SIG_W'(i) : HIT_THRESHOLD_RST + 1'b1,
                (i == 0) ? TIME_MAX :
                (i == 5) ? TIME_CUT_RST : TIME_CUT_RST + TIME_W'(i) + 1'b1);
      next_slot();
    end
    send_word(CMD_EOE, '0, '0, '0);
    next_slot();

    // Unknown channels ignored, a hit on the cut must not overwrite, then the
    // cuts change in mid event before an end of event carrying junk fields
    send_word(CMD_HIT, 5'd31, SIG_MAX, TIME_MAX);
    send_word(CMD_HIT, 5'd20, SIG_MAX, TIME_MAX);
    send_word(CMD_HIT, 5'd0, SIG_MAX, 16'd1000);
    send_word(CMD_HIT, 5'd0, HIT_THRESHOLD_RST, 16'd2000);
    send_word(CMD_HIT, 5'd6, HIT_THRESHOLD_RST + 1'b1, '0);
    set_config(24'd100000, TIME_CUT_RST, '0);
    send_word(CMD_EOE, 5'h1F, SIG_MAX, TIME_MAX);
    next_slot();

    // Random events under a series of settings, extremes first
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin thr = '0;      tcut = '0;       coinc = '0;      end
        1: begin thr = SIG_MAX; tcut = TIME_MAX; coinc = SIG_MAX; end
        2: begin
          thr   = SIG_W'($urandom_range(24'h400000, 24'hC00000));
          tcut  = TIME_W'($urandom_range(16'h2000, 16'hE000));
          coinc = SIG_W'($urandom_range(24'h400000, 24'hC00000));
        end
        3: begin thr = SIG_W'($urandom_range(0, 16'hFFFF)); tcut = TIME_MAX; coinc = '0; end
        4: begin
          thr   = HIT_THRESHOLD_RST;
          tcut  = TIME_CUT_RST;
          coinc = SIG_W'($urandom);
        end
        default: begin
          thr   = SIG_W'($urandom);
          tcut  = TIME_W'($urandom);
          coinc = SIG_W'($urandom);
        end
      endcase
      set_config(thr, tcut, coinc);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS)
        send_event($urandom_range(0, 12));
    end

    wait_drained();
    end_of_run <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
